>>> hw/rtl/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 7;
	localparam int STATUS_W     = 2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// access broadcast from the sequencer to every level cell
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [VALUE_W-1:0] wdata;
	} cell_cmd_t;

	// registered read data handed up the chain: entry at the index and the entry at the index with its low bit set
	typedef struct packed {
		logic [VALUE_W-1:0] next_word;
		logic [VALUE_W-1:0] at_word;
	} rd_pair_t;

endpackage

>>> hw/rtl/bhpq_if.sv
`timescale 1ns / 1ps

interface bhpq_op_if import bhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bhpq_res_if import bhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] top_value;
	logic                      is_empty;
	logic [COUNT_W-1:0]        entry_count;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output top_value, output is_empty, output entry_count,
		output status, input ready);
	modport sink   (input valid, input top_value, input is_empty, input entry_count,
		input status, output ready);
endinterface

interface bhpq_cfg_if ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bhpq_cell.sv
`timescale 1ns / 1ps

module bhpq_cell import bhpq_pkg::*; #(
	parameter int LEVEL    = 0,
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX_W    = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic [IDX_W-1:0] wr_idx,
	input  rd_pair_t         chain_in,
	output rd_pair_t         chain_out
);

	localparam int SPAN  = 1 << LEVEL;
	localparam int AVAIL = (CAPACITY + 1 - SPAN < SPAN) ? (CAPACITY + 1 - SPAN) : SPAN;
	localparam int EVEN  = ((AVAIL + 1) / 2) * 2;
	localparam int DEPTH = (EVEN < 2) ? 2 : EVEN;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [IDX_W-1:0] BASE = IDX_W'(SPAN);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic               rd_hit;
	logic               wr_hit;
	logic [AW-1:0]      rd_off;
	logic [AW-1:0]      wr_off;
	logic               sel_q;
	logic [VALUE_W-1:0] at_q;
	logic [VALUE_W-1:0] next_q;

	// 1-based heap index: level is the position of its top bit
	assign rd_hit = cmd.rd && ((rd_idx >> LEVEL) == IDX_W'(1));
	assign wr_hit = cmd.wr && ((wr_idx >> LEVEL) == IDX_W'(1));
	assign rd_off = AW'(rd_idx & ~BASE);
	assign wr_off = AW'(wr_idx & ~BASE);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_off] <= cmd.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_hit) begin
			at_q   <= mem[rd_off];
			next_q <= mem[rd_off | AW'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (cmd.rd) begin
			sel_q <= rd_hit;
		end
	end

	assign chain_out = sel_q ? rd_pair_t'{next_word: next_q, at_word: at_q} : chain_in;

endmodule

>>> hw/rtl/bhpq_seq.sv
`timescale 1ns / 1ps

module bhpq_seq import bhpq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX_W    = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	bhpq_op_if.sink          op,
	bhpq_res_if.source       res,
	input  logic             smallest_first,
	input  rd_pair_t         rd_data,
	output cell_cmd_t        cmd,
	output logic [IDX_W-1:0] rd_idx,
	output logic [IDX_W-1:0] wr_idx
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_RD    = 5'b00100,
		S_CMP   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// true when b belongs nearer the root than a
	function automatic logic yields(input logic sf, input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b);
		return sf ? (b < a) : (a < b);
	endfunction

	state_t                    state_q, state_d;
	logic                      kind_q, kind_d;
	logic signed [VALUE_W-1:0] m_q, m_d;
	logic [IDX_W-1:0]          j_q, j_d;
	logic [IDX_W-1:0]          cnt_q, cnt_d;
	logic [STATUS_W-1:0]       status_q, status_d;
	logic [VALUE_W-1:0]        top_q;
	logic                      out_valid_q;
	logic [VALUE_W-1:0]        out_top_q;
	logic                      out_empty_q;
	logic [COUNT_W-1:0]        out_count_q;
	logic [STATUS_W-1:0]       out_status_q;

	logic                      accept;
	logic                      load;
	logic [IDX_W:0]            child;
	logic [IDX_W:0]            child_odd;
	logic                      l_ok;
	logic                      r_ok;
	logic [VALUE_W-1:0]        best_val;
	logic [1:0]                best_sel;

	assign op.ready  = (state_q == S_IDLE);
	assign accept    = op.valid && op.ready;
	assign load      = (state_q == S_DONE) && (!out_valid_q || res.ready);
	assign child     = {j_q, 1'b0};
	assign child_odd = {j_q, 1'b1};
	assign l_ok      = child <= {1'b0, cnt_q};
	assign r_ok      = child_odd <= {1'b0, cnt_q};

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		m_d      = m_q;
		j_d      = j_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		cmd      = '0;
		rd_idx   = '0;
		wr_idx   = '0;
		best_val = m_q;
		best_sel = 2'd0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_d   = op.kind;
					status_d = STATUS_OK;
					if (op.kind == KIND_PUSH) begin
						if (cnt_q == IDX_W'(CAPACITY)) begin
							status_d = STATUS_FULL;
							state_d  = S_DONE;
						end else begin
							m_d     = op.value;
							j_d     = cnt_q + IDX_W'(1);
							cnt_d   = cnt_q + IDX_W'(1);
							state_d = S_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = STATUS_EMPTY;
							state_d  = S_DONE;
						end else begin
							cmd.rd  = 1'b1;
							rd_idx  = cnt_q;
							cnt_d   = cnt_q - IDX_W'(1);
							j_d     = IDX_W'(1);
							state_d = S_FETCH;
						end
					end
				end
			end
			S_FETCH: begin
				m_d     = rd_data.at_word;
				state_d = S_RD;
			end
			S_RD: begin
				if (kind_q == KIND_PUSH) begin
					if (j_q == IDX_W'(1)) begin
						cmd.wr    = 1'b1;
						cmd.wdata = m_q;
						wr_idx    = j_q;
						state_d   = S_DONE;
					end else begin
						cmd.rd  = 1'b1;
						rd_idx  = j_q >> 1;
						state_d = S_CMP;
					end
				end else begin
					if (!l_ok) begin
						cmd.wr    = 1'b1;
						cmd.wdata = m_q;
						wr_idx    = j_q;
						state_d   = S_DONE;
					end else begin
						cmd.rd  = 1'b1;
						rd_idx  = IDX_W'(child);
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				wr_idx = j_q;
				cmd.wr = 1'b1;
				if (kind_q == KIND_PUSH) begin
					if (yields(smallest_first, m_q, rd_data.at_word)) begin
						cmd.wdata = m_q;
						state_d   = S_DONE;
					end else begin
						cmd.wdata = rd_data.at_word;
						j_d       = j_q >> 1;
						state_d   = S_RD;
					end
				end else begin
					if (yields(smallest_first, m_q, rd_data.at_word)) begin
						best_val = rd_data.at_word;
						best_sel = 2'd1;
					end
					if (r_ok && yields(smallest_first, best_val, rd_data.next_word)) begin
						best_val = rd_data.next_word;
						best_sel = 2'd2;
					end
					if (best_sel == 2'd0) begin
						cmd.wdata = m_q;
						state_d   = S_DONE;
					end else begin
						cmd.wdata = best_val;
						j_d       = (best_sel == 2'd2) ? IDX_W'(child_odd) : IDX_W'(child);
						state_d   = S_RD;
					end
				end
			end
			S_DONE: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		m_q      <= m_d;
		j_q      <= j_d;
		status_q <= status_d;
		if (cmd.wr && (wr_idx == IDX_W'(1))) begin
			top_q <= cmd.wdata;
		end
		if (load) begin
			out_top_q    <= (cnt_q != '0) ? top_q : '0;
			out_empty_q  <= (cnt_q == '0);
			out_count_q  <= COUNT_W'(cnt_q);
			out_status_q <= status_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.top_value   = out_top_q;
	assign res.is_empty    = out_empty_q;
	assign res.entry_count = out_count_q;
	assign res.status      = out_status_q;

endmodule

>>> hw/rtl/binary_heap_priority_queue.sv
`timescale 1ns / 1ps

// Binary heap priority queue of signed 32-bit values, one heap level per cell, each cell
// holding its level's entries in a small memory with registered reads. One word at a time
// is processed: a push climbs level by level from the new leaf towards the root, a pop
// first fetches the last entry and sinks it level by level from the root, and a pop on
// empty or a push on full goes straight to the done state with its status. Each level step
// is one registered read of the level cells followed by one compare and write. The next
// word is accepted while a result still waits in the output register; a word that finishes
// while that register is still held waits in its last cycle until the result is taken.

module binary_heap_priority_queue import bhpq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bhpq_cfg_if.sink   cfg,
	bhpq_op_if.sink    op,
	bhpq_res_if.source res
);

	localparam int IDX_W  = $clog2(CAPACITY + 1);
	localparam int LEVELS = IDX_W;

	logic             smallest_first_q;
	cell_cmd_t        cmd;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	rd_pair_t         chain [LEVELS+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smallest_first_q <= 1'b0;
		end else if (cfg.valid) begin
			smallest_first_q <= cfg.data;
		end
	end

	assign chain[LEVELS] = '0;

	for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
		bhpq_cell #(
			.LEVEL    (lv),
			.CAPACITY (CAPACITY),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.rd_idx    (rd_idx),
			.wr_idx    (wr_idx),
			.chain_in  (chain[lv+1]),
			.chain_out (chain[lv])
		);
	end

	bhpq_seq #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.res            (res),
		.smallest_first (smallest_first_q),
		.rd_data        (chain[0]),
		.cmd            (cmd),
		.rd_idx         (rd_idx),
		.wr_idx         (wr_idx)
	);

endmodule

>>> hw/rtl/bhpq_checker.sv
`timescale 1ns / 1ps

module bhpq_checker import bhpq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                op_valid,
	input logic                op_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic [VALUE_W-1:0]  res_top_value,
	input logic                res_is_empty,
	input logic [COUNT_W-1:0]  res_entry_count,
	input logic [STATUS_W-1:0] res_status
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_top_value) && $stable(res_status)
			&& $stable(res_entry_count))
		else $error("stalled result word changed");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> !op_ready)
		else $error("second word taken while one is in work");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == STATUS_EMPTY) |-> res_is_empty && (res_top_value == '0))
		else $error("pop on empty reports a nonempty queue");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.op_valid        (op.valid),
	.op_ready        (op.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_top_value   (res.top_value),
	.res_is_empty    (res.is_empty),
	.res_entry_count (res.entry_count),
	.res_status      (res.status)
);
